// ----- sv/bse_pkg.sv -----
`default_nettype none
package bse_pkg;

	// register indexes of the configuration port
	localparam logic [2:0] REG_MIN_CELL   = 3'd0;
	localparam logic [2:0] REG_MAX_CELL   = 3'd1;
	localparam logic [2:0] REG_SEED_DROP  = 3'd2;
	localparam logic [2:0] REG_TAU        = 3'd3;
	localparam logic [2:0] REG_STORED     = 3'd4;

	localparam logic [13:0] SOC_FULL      = 14'd10000;
	localparam logic [5:0]  SOC_DIV_STEPS = 6'd32;
	localparam logic [5:0]  ALPHA_STEPS   = 6'd16;

	// commands from the controller, at most one set per cycle
	typedef struct packed {
		logic load;
		logic detect;
		logic calib;
		logic span;
		logic prod;
		logic div_soc;
		logic soc_clamp;
		logic prime;
		logic div_alpha;
		logic amul;
		logic update;
		logic out_load;
	} bse_cmd_t;

	typedef struct packed {
		logic div_done;
		logic span_pos;
		logic primed;
		logic out_free;
	} bse_sts_t;

endpackage
`default_nettype wire

// ----- sv/battery_soc_estimator_top.sv -----
// an item runs detection, calibration and span, then the charge quotient and
// smoothing (the first smoothed sample primes the filter); a span that is not
// positive goes straight to the result; one item in flight, and the bit-serial
// divider is shared (32 steps for the charge quotient, 16 for the smoothing weight)
// reset: arst_n asynchronous, active low; registers return to defaults, state clears
`default_nettype none
module battery_soc_estimator_top
	import bse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // pack_mv[14:0], now_ms[46:15], zero pad
	// result items
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // soc_centi_pct[13:0], cells[15:14], full_mv[30:16]
	// register writes, always taken
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data
);

	bse_cmd_t    cmd;
	bse_sts_t    sts;
	logic [13:0] soc;
	logic [1:0]  cells;
	logic [14:0] full;

	assign cfg_ready = 1'b1;

	// sequencer: one item in flight, result held in the output register
	bse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// cell detection, calibration, conversion and smoothing
	bse_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.pack_mv       (s_axis_tdata[14:0]),
		.now_ms        (s_axis_tdata[46:15]),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_ready     (m_axis_tready),
		.out_valid     (m_axis_tvalid),
		.soc_centi_pct (soc),
		.cells         (cells),
		.full_mv       (full)
	);

	assign m_axis_tdata = {1'b0, full, cells, soc};

endmodule
`default_nettype wire

// ----- sv/bse_div.sv -----
`default_nettype none
module bse_div
	import bse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [5:0]  steps,
	input  wire logic [32:0] rem_init,
	input  wire logic [31:0] num,
	input  wire logic [32:0] divisor,
	output logic             done,
	output logic [31:0]      quo
);

	logic [32:0] rem_q;
	logic [31:0] num_q;
	logic [31:0] quo_q;
	logic [32:0] div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [33:0] trial;
	logic        fits;

	// one restoring step per cycle
	assign trial = {rem_q, num_q[31]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			num_q <= num;
			quo_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? 33'(trial - {1'b0, div_q}) : trial[32:0];
			num_q <= {num_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule
`default_nettype wire

// ----- sv/bse_datapath.sv -----
`default_nettype none
module bse_datapath
	import bse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire bse_cmd_t    cmd,
	output bse_sts_t         sts,
	input  wire logic [14:0] pack_mv,
	input  wire logic [31:0] now_ms,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	input  wire logic        out_ready,
	output logic             out_valid,
	output logic [13:0]      soc_centi_pct,
	output logic [1:0]       cells,
	output logic [14:0]      full_mv
);

	logic [12:0] min_cell_q, max_cell_q;
	logic [9:0]  seed_drop_q;
	logic [15:0] tau_q;
	logic [14:0] stored_q;

	logic [14:0] v_q;
	logic [31:0] now_q;
	logic [1:0]  cell_q, ticks_q;
	logic        first_q;
	logic [14:0] calib_q;
	logic        primed_q;
	logic [13:0] smooth_q;
	logic [31:0] last_q;
	logic        span_pos_q, above_pos_q;
	logic [16:0] span_q, above_q;
	logic [29:0] prod_q;
	logic [13:0] soc_q;
	logic [29:0] aprod_q;
	logic        up_q;
	logic        valid_q;
	logic [13:0] soc_out_q;
	logic [1:0]  cells_out_q;
	logic [14:0] full_out_q;

	logic [14:0] nmax, nmin, ndrop, seed_val, base, calib_d;
	logic [16:0] three_max, five_max, two_v;
	logic [1:0]  raw_cnt;
	logic signed [18:0] delta, floor_v, span_v, above_v;
	logic        div_start, div_done;
	logic [5:0]  div_steps;
	logic [32:0] div_rem, div_dvs;
	logic [31:0] div_num, quo;
	logic [31:0] dt;
	logic [15:0] tau_eff;
	logic [13:0] diff;

	assign nmax  = 15'(cell_q) * 15'(max_cell_q);
	assign nmin  = 15'(cell_q) * 15'(min_cell_q);
	assign ndrop = 15'(cell_q) * 15'(seed_drop_q);

	assign two_v     = {1'b0, v_q, 1'b0};
	assign three_max = 17'(max_cell_q) * 17'd3;
	assign five_max  = 17'(max_cell_q) * 17'd5;
	assign raw_cnt   = (two_v < three_max) ? 2'd1 : (two_v < five_max) ? 2'd2 : 2'd3;

	assign seed_val = (stored_q != '0 && stored_q <= nmax) ? stored_q :
		(nmax >= ndrop) ? 15'(nmax - ndrop) : '0;
	assign base    = first_q ? seed_val : calib_q;
	assign calib_d = (v_q > base && v_q <= nmax) ? v_q : base;

	always_comb begin
		delta = 19'(signed'({4'b0, nmax})) - 19'(signed'({4'b0, calib_q}));
		if (delta < 0)
			delta = -delta;
		floor_v = 19'(signed'({4'b0, nmin})) - delta;
		span_v  = 19'(signed'({4'b0, calib_q})) - floor_v;
		above_v = 19'(signed'({4'b0, v_q})) - floor_v;
	end

	assign dt      = now_q - last_q;
	assign tau_eff = (tau_q == '0) ? 16'd1 : tau_q;
	assign diff    = (soc_q >= smooth_q) ? 14'(soc_q - smooth_q) : 14'(smooth_q - soc_q);

	assign div_start = cmd.div_soc | cmd.div_alpha;
	assign div_steps = cmd.div_alpha ? ALPHA_STEPS : SOC_DIV_STEPS;
	assign div_rem   = cmd.div_alpha ? {1'b0, dt} : '0;
	assign div_num   = cmd.div_alpha ? '0 : {2'b0, prod_q};
	assign div_dvs   = cmd.div_alpha ? 33'({1'b0, dt} + 33'(tau_eff)) : 33'(span_q);

	bse_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.steps    (div_steps),
		.rem_init (div_rem),
		.num      (div_num),
		.divisor  (div_dvs),
		.done     (div_done),
		.quo      (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_cell_q  <= 13'd3000;
			max_cell_q  <= 13'd4200;
			seed_drop_q <= 10'd50;
			tau_q       <= 16'd5000;
			stored_q    <= '0;
			cell_q      <= '0;
			ticks_q     <= '0;
			first_q     <= 1'b0;
			calib_q     <= '0;
			primed_q    <= 1'b0;
			smooth_q    <= '0;
			last_q      <= '0;
			span_pos_q  <= 1'b0;
			valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_CELL:  min_cell_q  <= cfg_data[12:0];
					REG_MAX_CELL:  max_cell_q  <= cfg_data[12:0];
					REG_SEED_DROP: seed_drop_q <= cfg_data[9:0];
					REG_TAU:       tau_q       <= cfg_data;
					REG_STORED:    stored_q    <= cfg_data[14:0];
					default: ;
				endcase
			end
			if (cmd.detect) begin
				first_q <= (cell_q == '0);
				if (cell_q == '0 || cell_q == raw_cnt) begin
					cell_q <= raw_cnt;
				end else if (ticks_q < 2'd2) begin
					ticks_q <= ticks_q + 2'd1;
				end else begin
					cell_q  <= raw_cnt;
					ticks_q <= '0;
				end
			end
			if (cmd.calib)
				calib_q <= calib_d;
			if (cmd.span)
				span_pos_q <= span_v > 0;
			if (cmd.prime) begin
				primed_q <= 1'b1;
				smooth_q <= soc_q;
				last_q   <= now_q;
			end
			if (cmd.update) begin
				smooth_q <= up_q ? 14'(smooth_q + aprod_q[29:16])
					: 14'(smooth_q - aprod_q[29:16]);
				last_q   <= now_q;
			end
			if (cmd.out_load)
				valid_q <= 1'b1;
			else if (out_ready)
				valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q   <= pack_mv;
			now_q <= now_ms;
		end
		if (cmd.span) begin
			above_pos_q <= above_v > 0;
			span_q      <= span_v[16:0];
			above_q     <= above_v[16:0];
		end
		if (cmd.prod)
			prod_q <= above_pos_q ? 30'(above_q * 30'd10000) : '0;
		if (cmd.soc_clamp)
			soc_q <= (quo > 32'(SOC_FULL)) ? SOC_FULL : quo[13:0];
		if (cmd.amul) begin
			up_q    <= soc_q >= smooth_q;
			aprod_q <= 30'(quo[15:0] * diff);
		end
		if (cmd.out_load) begin
			soc_out_q   <= span_pos_q ? smooth_q : '0;
			cells_out_q <= cell_q;
			full_out_q  <= calib_q;
		end
	end

	assign sts.div_done = div_done;
	assign sts.span_pos = span_pos_q;
	assign sts.primed   = primed_q;
	assign sts.out_free = !valid_q || out_ready;

	assign out_valid     = valid_q;
	assign soc_centi_pct = soc_out_q;
	assign cells         = cells_out_q;
	assign full_mv       = full_out_q;

endmodule
`default_nettype wire

// ----- sv/bse_ctrl.sv -----
`default_nettype none
module bse_ctrl
	import bse_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire bse_sts_t sts,
	output bse_cmd_t      cmd
);

	typedef enum logic [11:0] {
		ST_IDLE  = 12'b000000000001,
		ST_DET   = 12'b000000000010,
		ST_CAL   = 12'b000000000100,
		ST_SPAN  = 12'b000000001000,
		ST_PROD  = 12'b000000010000,
		ST_QDIV  = 12'b000000100000,
		ST_CLAMP = 12'b000001000000,
		ST_BR    = 12'b000010000000,
		ST_ADIV  = 12'b000100000000,
		ST_AMUL  = 12'b001000000000,
		ST_UPD   = 12'b010000000000,
		ST_FIN   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DET;
				end
			end
			ST_DET: begin
				cmd.detect = 1'b1;
				state_d    = ST_CAL;
			end
			ST_CAL: begin
				cmd.calib = 1'b1;
				state_d   = ST_SPAN;
			end
			ST_SPAN: begin
				cmd.span = 1'b1;
				state_d  = ST_PROD;
			end
			ST_PROD: begin
				if (sts.span_pos) begin
					cmd.prod = 1'b1;
					state_d  = ST_QDIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_QDIV: begin
				cmd.div_soc = 1'b1;
				state_d     = ST_CLAMP;
			end
			ST_CLAMP: begin
				if (sts.div_done) begin
					cmd.soc_clamp = 1'b1;
					state_d       = ST_BR;
				end
			end
			ST_BR: begin
				if (!sts.primed) begin
					cmd.prime = 1'b1;
					state_d   = ST_FIN;
				end else begin
					cmd.div_alpha = 1'b1;
					state_d       = ST_ADIV;
				end
			end
			ST_ADIV: begin
				if (sts.div_done)
					state_d = ST_AMUL;
			end
			ST_AMUL: begin
				cmd.amul = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_FIN;
			end
			ST_FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule
`default_nettype wire

// ----- sv/bse_checker.sv -----
`default_nettype none
module bse_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [31:0] m_axis_tdata
);

	// charge never beyond full scale
	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[13:0] <= 14'd10000)
		else $error("soc out of range");

	// a result always carries a detected cell count
	a_cells: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[15:14] != 2'd0)
		else $error("cell count zero");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

endmodule

bind battery_soc_estimator_top bse_checker u_bse_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
